[src/satq_pkg.sv]
// Shared types and constants of the sorted alarm timer queue.
package satq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned TIME_W = 64;
    localparam int unsigned ID_W = 8;

    typedef enum logic [2:0] {
        KIND_ARMED   = 3'd0,
        KIND_DROPPED = 3'd1,
        KIND_FULL    = 3'd2,
        KIND_WOKEN   = 3'd3,
        KIND_DONE    = 3'd4
    } t_kind;

    typedef enum logic [0:0] {
        CMD_ARM    = 1'b0,
        CMD_EXPIRE = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARM_CHK,
        ST_ARM_CMP,
        ST_ARM_PUT,
        ST_EXP_START,
        ST_EXP_SCAN,
        ST_EXP_RD,
        ST_EXP_WK,
        ST_OUT_WK,
        ST_OUT_LAST
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] wake;
        logic [ID_W-1:0]   id;
    } t_entry;

endpackage

[src/satq_if.sv]
// Command and result channel interfaces of the alarm queue.
interface satq_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  command;
    logic [7:0]  alarm_id;
    logic [63:0] base_time;
    logic [63:0] delay_ticks;
    logic [63:0] now_time;

    modport source (output valid, command, alarm_id, base_time, delay_ticks, now_time,
                    input ready);
    modport sink (input valid, command, alarm_id, base_time, delay_ticks, now_time,
                  output ready);
endinterface

interface satq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  woken_id;
    logic [63:0] compare_value;
    logic        timer_enable;
    logic        last;

    modport source (output valid, kind, woken_id, compare_value, timer_enable, last,
                    input ready);
    modport sink (input valid, kind, woken_id, compare_value, timer_enable, last,
                  output ready);
endinterface

[src/satq_mem.sv]
// Entry memory of the alarm queue: one write port, one registered read port.
module satq_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  satq_pkg::t_entry i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output satq_pkg::t_entry o_rdata
);
    import satq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/sorted_alarm_timer_queue_unit.sv]
// Top level of the sorted alarm timer queue: sequencer around a circular entry memory.
//
//  channel  | dir | handshake    | word
//  ---------+-----+--------------+--------------------------------------------
//  i_cmd    | in  | valid/ready  | command, alarm_id, base_time, delay, now
//  o_res    | out | valid/ready  | kind, woken_id, compare_value, enable, last
//
// A dropped, refused or first arm goes from the check straight to its result; any
// other arm first moves each later entry up one slot to make room, then writes.
// An expire scans the due entries at one per cycle up to the first entry not due,
// then reads, wakes and outputs each woken word in turn; every result waits in the
// output register until taken.
// Entries live in a circular buffer, so expiry only moves the head pointer.
// Reset clears the count and control state; the memory itself needs no clearing.
// One command is handled at a time; a new command is taken once the last word left.
module sorted_alarm_timer_queue_unit #(
    parameter int unsigned QUEUE_DEPTH = satq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    satq_in_if.sink       i_cmd,
    satq_out_if.source    o_res
);
    import satq_pkg::*;

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head, n_head;
    logic [TIME_W-1:0] r_head_wake, n_head_wake;
    logic [TIME_W-1:0] r_wake, n_wake;
    logic [ID_W-1:0] r_id, n_id;
    logic [TIME_W-1:0] r_now, n_now;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_due, n_due;
    logic [CW-1:0] r_fin_cnt, n_fin_cnt;
    logic [TIME_W-1:0] r_fin_wake, n_fin_wake;

    logic r_ov, n_ov;
    t_kind r_okind, n_okind;
    logic [ID_W-1:0] r_oid, n_oid;
    logic [TIME_W-1:0] r_ocmp, n_ocmp;
    logic r_oen, n_oen;
    logic r_olast, n_olast;

    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_entry mem_wdata, mem_rdata;

    logic accept;
    logic [TIME_W:0] wake_sum;
    logic [TIME_W-1:0] wake_sat;
    logic is_past, is_full;

    // Logical slot (offset from head) to memory address, wrapping at the depth.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
        logic [CW-1:0] s;
        s = CW'(head) + l;
        if (s >= DEPTH_C) begin
            s = s - DEPTH_C;
        end
        return s[AW-1:0];
    endfunction

    satq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign wake_sum = {1'b0, i_cmd.base_time} + {1'b0, i_cmd.delay_ticks};
    assign wake_sat = wake_sum[TIME_W] ? '1 : wake_sum[TIME_W-1:0];
    assign is_past  = r_wake < r_now;
    assign is_full  = r_count >= DEPTH_C;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (t_cmd'(i_cmd.command) == CMD_EXPIRE) ? ST_EXP_START : ST_ARM_CHK;
                end
            end
            ST_ARM_CHK: begin
                if (is_past || is_full || r_count == '0) begin
                    n_state = ST_OUT_LAST;
                end else begin
                    n_state = ST_ARM_CMP;
                end
            end
            ST_ARM_CMP: begin
                if (mem_rdata.wake > r_wake) begin
                    n_state = (r_idx == CW'(1)) ? ST_ARM_PUT : ST_ARM_CMP;
                end else begin
                    n_state = ST_OUT_LAST;
                end
            end
            ST_ARM_PUT:   n_state = ST_OUT_LAST;
            ST_EXP_START: n_state = (r_count == '0) ? ST_OUT_LAST : ST_EXP_SCAN;
            ST_EXP_SCAN: begin
                if (mem_rdata.wake <= r_now) begin
                    n_state = (r_idx + CW'(1) == r_count) ? ST_EXP_RD : ST_EXP_SCAN;
                end else begin
                    n_state = (r_idx == '0) ? ST_OUT_LAST : ST_EXP_RD;
                end
            end
            ST_EXP_RD: n_state = ST_EXP_WK;
            ST_EXP_WK: n_state = ST_OUT_WK;
            ST_OUT_WK: begin
                if (o_res.ready) begin
                    n_state = (r_idx + CW'(1) == r_due) ? ST_OUT_LAST : ST_EXP_RD;
                end
            end
            ST_OUT_LAST: begin
                if (o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_head      = r_head;
        n_head_wake = r_head_wake;
        n_wake      = r_wake;
        n_id        = r_id;
        n_now       = r_now;
        n_idx       = r_idx;
        n_due       = r_due;
        n_fin_cnt   = r_fin_cnt;
        n_fin_wake  = r_fin_wake;
        n_ov        = r_ov;
        n_okind     = r_okind;
        n_oid       = r_oid;
        n_ocmp      = r_ocmp;
        n_oen       = r_oen;
        n_olast     = r_olast;
        mem_we      = 1'b0;
        mem_waddr   = phys(r_head, r_idx);
        mem_wdata   = mem_rdata;
        mem_raddr   = phys(r_head, r_idx);
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_wake = wake_sat;
                    n_id   = i_cmd.alarm_id;
                    n_now  = i_cmd.now_time;
                    n_idx  = (t_cmd'(i_cmd.command) == CMD_EXPIRE) ? '0 : r_count;
                    n_due  = '0;
                end
            end
            ST_ARM_CHK: begin
                n_ov    = 1'b1;
                n_oid   = '0;
                n_olast = 1'b1;
                n_ocmp  = (r_count != '0) ? r_head_wake : '1;
                n_oen   = (r_count != '0);
                mem_raddr = phys(r_head, r_idx - CW'(1));
                if (is_past) begin
                    n_okind = KIND_DROPPED;
                end else if (is_full) begin
                    n_okind = KIND_FULL;
                end else if (r_count == '0) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_head;
                    mem_wdata   = '{wake: r_wake, id: r_id};
                    n_head_wake = r_wake;
                    n_count     = r_count + CW'(1);
                    n_okind     = KIND_ARMED;
                    n_ocmp      = r_wake;
                    n_oen       = 1'b1;
                end else begin
                    n_ov = 1'b0;
                end
            end
            ST_ARM_CMP: begin
                mem_we = 1'b1;
                if (mem_rdata.wake > r_wake) begin
                    // Shift the later entry up one slot and look one further down.
                    n_idx     = r_idx - CW'(1);
                    mem_raddr = phys(r_head, r_idx - CW'(2));
                end else begin
                    mem_wdata = '{wake: r_wake, id: r_id};
                    n_count   = r_count + CW'(1);
                    n_ov      = 1'b1;
                    n_okind   = KIND_ARMED;
                    n_oid     = '0;
                    n_olast   = 1'b1;
                    n_ocmp    = r_head_wake;
                    n_oen     = 1'b1;
                end
            end
            ST_ARM_PUT: begin
                mem_we      = 1'b1;
                mem_waddr   = r_head;
                mem_wdata   = '{wake: r_wake, id: r_id};
                n_head_wake = r_wake;
                n_count     = r_count + CW'(1);
                n_ov        = 1'b1;
                n_okind     = KIND_ARMED;
                n_oid       = '0;
                n_olast     = 1'b1;
                n_ocmp      = r_wake;
                n_oen       = 1'b1;
            end
            ST_EXP_START: begin
                mem_raddr = r_head;
                if (r_count == '0) begin
                    n_ov    = 1'b1;
                    n_okind = KIND_DONE;
                    n_oid   = '0;
                    n_olast = 1'b1;
                    n_ocmp  = '1;
                    n_oen   = 1'b0;
                end
            end
            ST_EXP_SCAN: begin
                if (mem_rdata.wake <= r_now) begin
                    n_idx     = r_idx + CW'(1);
                    mem_raddr = phys(r_head, r_idx + CW'(1));
                    if (r_idx + CW'(1) == r_count) begin
                        n_due     = r_count;
                        n_fin_cnt = '0;
                        n_idx     = '0;
                    end
                end else if (r_idx == '0) begin
                    n_ov    = 1'b1;
                    n_okind = KIND_DONE;
                    n_oid   = '0;
                    n_olast = 1'b1;
                    n_ocmp  = r_head_wake;
                    n_oen   = 1'b1;
                end else begin
                    n_due      = r_idx;
                    n_fin_cnt  = r_count - r_idx;
                    n_fin_wake = mem_rdata.wake;
                    n_idx      = '0;
                end
            end
            ST_EXP_RD: begin
                mem_raddr = phys(r_head, r_idx);
            end
            ST_EXP_WK: begin
                n_ov    = 1'b1;
                n_okind = KIND_WOKEN;
                n_oid   = mem_rdata.id;
                n_olast = 1'b0;
                n_ocmp  = (r_fin_cnt != '0) ? r_fin_wake : '1;
                n_oen   = (r_fin_cnt != '0);
            end
            ST_OUT_WK: begin
                if (o_res.ready) begin
                    if (r_idx + CW'(1) == r_due) begin
                        // All woken words are out: commit the new head and count.
                        n_head      = phys(r_head, r_due);
                        n_count     = r_fin_cnt;
                        n_head_wake = r_fin_wake;
                        n_okind     = KIND_DONE;
                        n_oid       = '0;
                        n_olast     = 1'b1;
                    end else begin
                        n_idx = r_idx + CW'(1);
                        n_ov  = 1'b0;
                    end
                end
            end
            ST_OUT_LAST: begin
                if (o_res.ready) begin
                    n_ov = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_ov    <= n_ov;
        end
        r_head_wake <= n_head_wake;
        r_wake      <= n_wake;
        r_id        <= n_id;
        r_now       <= n_now;
        r_idx       <= n_idx;
        r_due       <= n_due;
        r_fin_cnt   <= n_fin_cnt;
        r_fin_wake  <= n_fin_wake;
        r_okind     <= n_okind;
        r_oid       <= n_oid;
        r_ocmp      <= n_ocmp;
        r_oen       <= n_oen;
        r_olast     <= n_olast;
    end

    assign i_cmd.ready         = (r_state == ST_IDLE);
    assign o_res.valid         = r_ov;
    assign o_res.kind          = r_okind;
    assign o_res.woken_id      = r_oid;
    assign o_res.compare_value = r_ocmp;
    assign o_res.timer_enable  = r_oen;
    assign o_res.last          = r_olast;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C) else $error("entry count exceeds depth");
    a_ready_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> !o_res.valid) else $error("command taken while a word is pending");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_cmd.ready) else $error("second command taken back to back");
    a_empty_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.timer_enable) |-> (o_res.compare_value == '1))
        else $error("compare value not all ones on an empty queue");
`endif

endmodule

[tb/sorted_alarm_timer_queue_unit_tb.sv]
// Testbench for the sorted alarm timer queue: random arm and expire traffic checked against a model.
`timescale 1ns / 1ps

module sorted_alarm_timer_queue_unit_tb;
    import satq_pkg::*;

    localparam int unsigned DEPTH = 16;
    localparam logic [63:0] ALL_ONES = '1;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  woken_id;
        logic [63:0] compare_value;
        logic        timer_enable;
        logic        last;
    } t_result;

    class alarm_scoreboard;
        logic [63:0] wake_q[$];
        logic [7:0]  id_q[$];
        t_result     pending[$];
        int          errors;

        function void note_command(logic [0:0] cmd, logic [7:0] id, logic [63:0] base,
                                   logic [63:0] dly, logic [63:0] now);
            t_result     res[$];
            t_result     r;
            logic [64:0] sum;
            logic [63:0] wake;
            int          pos;
            res = {};
            if (cmd == CMD_ARM) begin
                sum = {1'b0, base} + {1'b0, dly};
                wake = sum[64] ? ALL_ONES : sum[63:0];
                r = '0;
                r.last = 1'b1;
                if (wake < now) begin
                    r.kind = KIND_DROPPED;
                end else if (wake_q.size() >= DEPTH) begin
                    r.kind = KIND_FULL;
                end else begin
                    // Equal wake times keep their arrival order.
                    pos = 0;
                    while (pos < wake_q.size() && wake_q[pos] <= wake) pos++;
                    wake_q.insert(pos, wake);
                    id_q.insert(pos, id);
                    r.kind = KIND_ARMED;
                end
                res.push_back(r);
            end else begin
                while (wake_q.size() > 0 && wake_q[0] <= now) begin
                    r = '0;
                    r.kind = KIND_WOKEN;
                    r.woken_id = id_q.pop_front();
                    void'(wake_q.pop_front());
                    res.push_back(r);
                end
                r = '0;
                r.kind = KIND_DONE;
                r.last = 1'b1;
                res.push_back(r);
            end
            foreach (res[k]) begin
                res[k].compare_value = wake_q.size() > 0 ? wake_q[0] : ALL_ONES;
                res[k].timer_enable = wake_q.size() > 0;
                pending.push_back(res[k]);
            end
        endfunction

        function void check_result(t_result act);
            t_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, act);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (act !== exp_r) begin
                $display("%0t: mismatch expected %p actual %p", $time, exp_r, act);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    satq_in_if  cmd_ch();
    satq_out_if res_ch();

    sorted_alarm_timer_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd_ch.sink), .o_res(res_ch.source)
    );

    alarm_scoreboard sb;
    bit long_hold;
    bit sending_done;
    logic [63:0] sim_now;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("sorted_alarm_timer_queue_unit_tb failed");
        $finish;
    end

    // Monitor: accepted commands and results, sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready)
            sb.note_command(cmd_ch.command, cmd_ch.alarm_id, cmd_ch.base_time,
                            cmd_ch.delay_ticks, cmd_ch.now_time);
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result({t_kind'(res_ch.kind), res_ch.woken_id, res_ch.compare_value,
                             res_ch.timer_enable, res_ch.last});
    end

    // Receiver stall pattern, with one long hold-off on request.
    initial begin
        int phase;
        res_ch.ready = 1'b0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (long_hold)
                res_ch.ready <= 1'b0;
            else if ((phase / 64) % 3 == 0)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_command(logic [0:0] cmd, logic [7:0] id, logic [63:0] base,
                                logic [63:0] dly, logic [63:0] now);
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.alarm_id <= id;
        cmd_ch.base_time <= base;
        cmd_ch.delay_ticks <= dly;
        cmd_ch.now_time <= now;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int n);
        cmd_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random arm: wake times cluster near the running clock so expiries wake many.
    task automatic random_arm();
        logic [63:0] base, dly, now;
        int sel;
        sel = $urandom_range(0, 9);
        now = sim_now;
        base = sim_now - 64'($urandom_range(0, 20));
        dly = 64'($urandom_range(0, 60));
        if (sel == 0) begin
            base = rand64();
            dly = rand64();
            now = rand64();
        end else if (sel == 1) begin
            dly = ALL_ONES - 64'($urandom_range(0, 3));
        end
        send_command(CMD_ARM, 8'($urandom()), base, dly, now);
    endtask

    task automatic random_expire();
        logic [63:0] now;
        sim_now += 64'($urandom_range(0, 30));
        now = sim_now;
        if ($urandom_range(0, 15) == 0) now = rand64();
        send_command(CMD_EXPIRE, 8'($urandom()), rand64(), rand64(), now);
    endtask

    initial begin
        int burst, wait_cycles;
        sb = new();
        long_hold = 1'b0;
        sending_done = 1'b0;
        sim_now = 64'd1000;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_ARM;
        cmd_ch.alarm_id = '0;
        cmd_ch.base_time = '0;
        cmd_ch.delay_ticks = '0;
        cmd_ch.now_time = '0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty expire, saturation, equal-to-now, past, ties, full queue.
        send_command(CMD_EXPIRE, 8'h00, '0, '0, '0);
        send_command(CMD_ARM, 8'hFF, ALL_ONES, ALL_ONES, ALL_ONES);
        send_command(CMD_ARM, 8'h01, 64'd50, 64'd50, 64'd100);
        send_command(CMD_ARM, 8'h02, 64'd10, 64'd10, 64'd100);
        send_command(CMD_ARM, 8'h03, 64'd0, 64'd100, 64'd0);
        send_command(CMD_ARM, 8'h04, 64'd0, 64'd0, 64'd0);
        send_command(CMD_EXPIRE, 8'hAA, ALL_ONES, ALL_ONES, 64'd100);
        for (int i = 0; i < 16; i++)
            send_command(CMD_ARM, i[7:0], 64'd200, 64'(i % 4), 64'd0);
        send_command(CMD_ARM, 8'h55, 64'd300, 64'd0, 64'd0);
        send_command(CMD_ARM, 8'h66, 64'd0, 64'd0, 64'd1);
        send_command(CMD_EXPIRE, 8'h00, '0, '0, ALL_ONES);

        // Long receiver hold-off while commands keep coming.
        fork
            begin
                long_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end
            for (int i = 0; i < 12; i++) random_arm();
        join

        for (int n = 0; n < 400; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++, n++) begin
                if ($urandom_range(0, 3) == 0) random_expire();
                else random_arm();
            end
            if ($urandom_range(0, 1)) idle_gap($urandom_range(1, 40));
        end
        cmd_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("sorted_alarm_timer_queue_unit_tb passed");
        else
            $display("sorted_alarm_timer_queue_unit_tb failed");
        $finish;
    end

endmodule

[sorted_alarm_timer_queue_unit.f]
src/satq_pkg.sv
src/satq_if.sv
src/satq_mem.sv
src/sorted_alarm_timer_queue_unit.sv
tb/sorted_alarm_timer_queue_unit_tb.sv
